@@ rtl/core/octave_band_peak_detector_unit_assert.svh @@
// Assertion macros for the octave band peak detector.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef OCTAVE_BAND_PEAK_DETECTOR_UNIT_ASSERT_SVH
`define OCTAVE_BAND_PEAK_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define OBPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OBPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/obpd_pkg.sv @@
// Package for the octave band peak detector: shared types and constants.
// No dependencies.
package obpd_pkg;

    localparam int BIN_WIDTH = 24;
    localparam int MAG_W = 2 * BIN_WIDTH;
    localparam int BIN_W = 15;
    localparam int LOG_W = 22;

    // Configuration register indexes.
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_FRAME_LENGTH = 1'b1;

    localparam logic [31:0] LN_K = 32'd58145400;
    localparam logic [31:0] LOG10_K = 32'd25252226;

    // Band edge table, entry i is the lower edge of band i.
    function automatic logic [13:0] band_edge(input logic [3:0] i);
        logic [13:0] e;
        begin
            case (i)
                4'd0: e = 14'd16;
                4'd1: e = 14'd33;
                4'd2: e = 14'd65;
                4'd3: e = 14'd131;
                4'd4: e = 14'd262;
                4'd5: e = 14'd523;
                4'd6: e = 14'd1047;
                4'd7: e = 14'd2093;
                4'd8: e = 14'd4196;
                4'd9: e = 14'd8372;
                default: e = 14'd15805;
            endcase
            return e;
        end
    endfunction

    // Frame summary handed from the front part to the back part.
    typedef struct packed {
        logic [9:0][MAG_W-1:0] band_mag;
        logic [MAG_W-1:0]      peak_mag;
        logic [BIN_W-1:0]      peak_bin;
        logic [17:0]           rate;
        logic [16:0]           length;
    } frame_sum_t;

endpackage

@@ rtl/core/obpd_front.sv @@
// Front part: counts bins, forms squared magnitudes and tracks peaks.
// Depends on obpd_pkg.
module obpd_front #(
    parameter int NUM_BANDS = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [obpd_pkg::BIN_WIDTH-1:0] re,
    input  logic signed [obpd_pkg::BIN_WIDTH-1:0] im,
    input  logic                      last_in,
    input  logic [17:0]               rate,
    input  logic [16:0]               length,
    output logic                      sum_valid,
    input  logic                      sum_ready,
    output obpd_pkg::frame_sum_t      sum
);
    localparam int MW = obpd_pkg::MAG_W;
    localparam int BW = obpd_pkg::BIN_WIDTH;

    // Stage 1 registers: magnitude terms and band hit flags.
    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic                   s1_used_reg;
    logic [MW-1:0]          s1_mag_reg;
    logic [15:0]            s1_bin_reg;
    logic [NUM_BANDS-1:0]   s1_hit_reg;
    logic [15:0]            bin_count_reg;
    logic [9:0][MW-1:0]     band_reg;
    logic [MW-1:0]          peak_reg;
    logic [obpd_pkg::BIN_W-1:0] pbin_reg;
    logic                   out_valid_reg;
    obpd_pkg::frame_sum_t   out_reg;

    logic [BW-1:0] ar, ai;
    logic [16:0] half;
    logic [33:0] fnum;
    logic [NUM_BANDS:0] above;
    logic [NUM_BANDS-1:0] hit;
    logic take;
    logic stall;
    logic hand_off;

    assign stall = s1_valid_reg && s1_last_reg && out_valid_reg && !sum_ready;
    assign in_ready = !stall;
    assign take = in_valid && in_ready;
    assign hand_off = s1_valid_reg && !stall && s1_last_reg;
    assign ar = re[BW-1] ? BW'(-re) : BW'(re);
    assign ai = im[BW-1] ? BW'(-im) : BW'(im);
    assign half = (length[16:1] > 16'd32768) ? 17'd32768 : {1'b0, length[16:1]};
    assign fnum = 34'(bin_count_reg) * 34'(rate);

    // Edge compares against edge*length.
    always_comb
    begin
        for (int i = 0; i <= NUM_BANDS; i++)
        begin
            above[i] = fnum > (34'(obpd_pkg::band_edge(4'(i))) * 34'(length));
        end
        for (int i = 0; i < NUM_BANDS; i++)
        begin
            hit[i] = above[i] && !above[i+1];
        end
    end

    // Bin counter and stage 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= take;
            if (take)
            begin
                s1_last_reg <= last_in;
                if (last_in)
                    bin_count_reg <= '0;
                else if (bin_count_reg != 16'hFFFF)
                    bin_count_reg <= bin_count_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_used_reg <= {1'b0, bin_count_reg} < half;
            s1_mag_reg <= MW'(ar) * MW'(ar) + MW'(ai) * MW'(ai);
            s1_bin_reg <= bin_count_reg;
            s1_hit_reg <= hit;
        end
    end

    // Peak tracking and frame hand-off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= '0;
            peak_reg <= '0;
            pbin_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && sum_ready && !hand_off)
                out_valid_reg <= 1'b0;
            if (s1_valid_reg && !stall)
            begin
                logic [9:0][MW-1:0] nb;
                logic [MW-1:0] np;
                logic [obpd_pkg::BIN_W-1:0] nbin;
                nb = band_reg;
                np = peak_reg;
                nbin = pbin_reg;
                if (s1_used_reg)
                begin
                    for (int i = 0; i < NUM_BANDS; i++)
                    begin
                        if (s1_hit_reg[i] && s1_mag_reg > band_reg[i])
                            nb[i] = s1_mag_reg;
                    end
                    if (s1_mag_reg > peak_reg)
                    begin
                        np = s1_mag_reg;
                        nbin = s1_bin_reg[obpd_pkg::BIN_W-1:0];
                    end
                end
                if (s1_last_reg)
                begin
                    out_reg.band_mag <= nb;
                    out_reg.peak_mag <= np;
                    out_reg.peak_bin <= nbin;
                    out_reg.rate <= rate;
                    out_reg.length <= length;
                    out_valid_reg <= 1'b1;
                    band_reg <= '0;
                    peak_reg <= '0;
                    pbin_reg <= '0;
                end
                else
                begin
                    band_reg <= nb;
                    peak_reg <= np;
                    pbin_reg <= nbin;
                end
            end
        end
    end

    assign sum_valid = out_valid_reg;
    assign sum = out_reg;
endmodule

@@ rtl/core/obpd_back.sv @@
// Back part: log conversion, peak frequency division and result emission.
// Depends on obpd_pkg.
module obpd_back #(
    parameter int NUM_BANDS = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sum_valid,
    output logic                 sum_ready,
    input  obpd_pkg::frame_sum_t sum,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [39:0]          res_data,
    output logic                 res_last
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_NORM = 6'b000010,
        ST_SQR  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    obpd_pkg::frame_sum_t fr_reg;
    logic [3:0]  idx_reg;
    logic [47:0] mag_reg;
    logic [30:0] y_reg;
    logic [4:0]  it_reg;
    logic [obpd_pkg::LOG_W-1:0] r_reg;
    logic [53:0] prod_reg;
    logic [33:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        out_last_reg;

    logic is_overall;
    logic [61:0] sq;
    logic [47:0] cur_mag;
    logic [53:0] rounded;
    logic [17:0] rem_shift;
    logic [5:0] top;

    assign is_overall = (idx_reg == 4'(NUM_BANDS));
    assign cur_mag = is_overall ? fr_reg.peak_mag : fr_reg.band_mag[idx_reg];
    assign sq = 62'(y_reg) * 62'(y_reg);
    assign sum_ready = (state_reg == ST_IDLE);
    assign rounded = prod_reg + 54'h80000000;
    assign rem_shift = {rem_reg, quo_reg[33]};

    // Index of the top set bit of the magnitude.
    always_comb
    begin
        top = '0;
        for (int i = 0; i < 48; i++)
        begin
            if (mag_reg[i])
                top = 6'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && res_ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sum_valid)
                    begin
                        fr_reg <= sum;
                        idx_reg <= '0;
                        mag_reg <= sum.band_mag[0];
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    mag_reg <= cur_mag;
                    if (top >= 6'd30)
                        y_reg <= 31'(mag_reg >> (top - 6'd30));
                    else
                        y_reg <= 31'(mag_reg << (6'd30 - top));
                    r_reg <= {top, 16'd0};
                    it_reg <= 5'd15;
                    state_reg <= ST_SQR;
                end
                ST_SQR:
                begin
                    if (sq[61])
                    begin
                        y_reg <= 31'(sq >> 31);
                        r_reg[it_reg[3:0]] <= 1'b1;
                    end
                    else
                        y_reg <= 31'(sq >> 30);
                    if (it_reg == 5'd0)
                        state_reg <= ST_MUL;
                    it_reg <= it_reg - 5'd1;
                end
                ST_MUL:
                begin
                    prod_reg <= 54'(r_reg) * 54'(is_overall ? obpd_pkg::LOG10_K
                                                            : obpd_pkg::LN_K);
                    quo_reg <= 34'(fr_reg.peak_bin) * 34'(fr_reg.rate);
                    rem_reg <= '0;
                    dcnt_reg <= 6'd34;
                    state_reg <= is_overall ? ST_DIV : ST_OUT;
                end
                ST_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (dcnt_reg == 6'd0)
                        state_reg <= ST_OUT;
                    else
                    begin
                        dcnt_reg <= dcnt_reg - 6'd1;
                        if (rem_shift >= {1'b0, fr_reg.length})
                        begin
                            rem_reg <= 17'(rem_shift - {1'b0, fr_reg.length});
                            quo_reg <= {quo_reg[32:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_shift[16:0];
                            quo_reg <= {quo_reg[32:0], 1'b0};
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || res_ready)
                    begin
                        logic e;
                        logic [21:0] lv;
                        logic [15:0] lvs;
                        logic [16:0] f;
                        e = (mag_reg == 48'd0);
                        lv = rounded[53:32];
                        lvs = (lv > 22'd65535) ? 16'hFFFF : lv[15:0];
                        f = (e || fr_reg.length == 17'd0) ? 17'd0 : quo_reg[16:0];
                        out_valid_reg <= 1'b1;
                        out_last_reg <= is_overall;
                        // Packed as band, level, peak frequency, empty flag.
                        out_data_reg <= {2'd0, e, (is_overall ? f : 17'd0),
                                         (e ? 16'd0 : lvs),
                                         (is_overall ? 4'd0 : idx_reg)};
                        if (is_overall)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            idx_reg <= idx_reg + 4'd1;
                            mag_reg <= (idx_reg + 4'd1 == 4'(NUM_BANDS)) ? fr_reg.peak_mag
                                       : fr_reg.band_mag[idx_reg + 4'd1];
                            state_reg <= ST_NORM;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res_last = out_last_reg;
    assign res_data = out_data_reg;
endmodule

@@ rtl/core/octave_band_peak_detector_unit.sv @@
// Octave band peak detector. Takes one FFT bin per cycle in a frame, unless the
// input stalls; after the last bin it emits nine band levels and one overall
// result. The front part accepts one bin per clock when not stalled and hands a
// frame summary on through its stage 1 registers and its summary register. The
// back part forms each band result by normalize, 16 squaring steps, scale and
// output, and the overall result by the same plus a 34-step restoring divider;
// output stalls hold it in the output step. A frame summary register between
// the two lets the next frame's bins arrive meanwhile, and input stalls only
// when the last bin of yet another frame arrives while that register still
// holds a waiting summary.
// Depends on obpd_pkg, obpd_front, obpd_back and the assertion header.
`include "octave_band_peak_detector_unit_assert.svh"
module octave_band_peak_detector_unit #(
    parameter int NUM_BANDS = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*obpd_pkg::BIN_WIDTH-1:0] s_tdata,   // bin_real, bin_imag
    input  logic                   s_tlast,   // last_bin
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // band, level, peak_freq_hz, empty_res
    output logic                   m_tuser,   // kind
    output logic                   m_tlast,   // last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [17:0]            cfg_data
);
    localparam int BW = obpd_pkg::BIN_WIDTH;

    logic [17:0] rate_reg;
    logic [16:0] length_reg;
    logic sum_valid, sum_ready;
    obpd_pkg::frame_sum_t sum;
    logic [39:0] bd;
    logic bl;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 18'd44100;
            length_reg <= 17'd4096;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == obpd_pkg::REG_SAMPLE_RATE)
                rate_reg <= cfg_data;
            else if (cfg_index == obpd_pkg::REG_FRAME_LENGTH)
                length_reg <= cfg_data[16:0];
        end
    end

    obpd_front #(.NUM_BANDS(NUM_BANDS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .re(s_tdata[BW-1:0]), .im(s_tdata[2*BW-1:BW]),
        .last_in(s_tlast), .rate(rate_reg), .length(length_reg),
        .sum_valid(sum_valid), .sum_ready(sum_ready), .sum(sum)
    );

    obpd_back #(.NUM_BANDS(NUM_BANDS)) u_back (
        .clk(clk), .rst_n(rst_n), .sum_valid(sum_valid), .sum_ready(sum_ready),
        .sum(sum), .res_valid(m_tvalid), .res_ready(m_tready),
        .res_data(bd), .res_last(bl)
    );

    // Output packing: the overall result is both the kind flag and the last one.
    assign m_tlast = bl;
    assign m_tuser = bl;
    assign m_tdata = bd;

    `OBPD_ASSERT_IMP(a_last_kind, clk, rst_n, m_tvalid, m_tlast == m_tuser)
    `OBPD_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
endmodule
